[design/mrld_pkg.sv]
// Shared types, codes and single-precision helper functions of the run-length decoder.
package mrld_pkg;

    localparam logic [2:0] KIND_CONST   = 3'd0;
    localparam logic [2:0] KIND_ASCEND  = 3'd1;
    localparam logic [2:0] KIND_DESCEND = 3'd2;
    localparam logic [2:0] KIND_DELTA   = 3'd3;
    localparam logic [2:0] KIND_FLOAT   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_REFUSED   = 2'd1;
    localparam logic [1:0] ST_NO_RUN    = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    localparam logic [2:0] REG_SYM_CONST   = 3'd0;
    localparam logic [2:0] REG_SYM_ASCEND  = 3'd1;
    localparam logic [2:0] REG_SYM_DESCEND = 3'd2;
    localparam logic [2:0] REG_SYM_DELTA   = 3'd3;
    localparam logic [2:0] REG_SYM_FLOATS  = 3'd4;

    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

    // Item as it leaves the decode stage.
    typedef struct packed {
        logic        val_valid;
        logic        run_pending;
        logic [1:0]  status;
        logic        elem;
        logic [2:0]  kind;
        logic [30:0] index;
        logic [31:0] word;
        logic [31:0] first;
        logic [31:0] step;
    } dec_t;

    // Item as it travels through the float stages.
    typedef struct packed {
        logic        val_valid;
        logic        run_pending;
        logic [1:0]  status;
        logic        is_float;
        logic [31:0] value;
        logic [31:0] first;
        logic [31:0] step;
    } item_t;

    // Unrounded float: value = mn * 2^(en - 174) unless spec is set.
    typedef struct packed {
        logic               spec;
        logic [31:0]        sval;
        logic               sign;
        logic               zero;
        logic signed [11:0] en;
        logic [49:0]        mn;
    } fl_t;

    function automatic logic [31:0] int_elem(logic [2:0] kind, logic [31:0] first,
                                             logic [31:0] step, logic [30:0] idx);
        logic [31:0] i32;
        i32 = {1'b0, idx};
        case (kind)
            KIND_CONST:   int_elem = first;
            KIND_ASCEND:  int_elem = first + i32;
            KIND_DESCEND: int_elem = first - i32;
            KIND_DELTA:   int_elem = first + i32 * step;
            default:      int_elem = first;
        endcase
    endfunction

    // Moves the leading one to bit 49 and adjusts the exponent so that a
    // leading one at bit 47 with exponent e means biased exponent e.
    function automatic fl_t fnorm(fl_t x);
        fl_t        y;
        logic [5:0] p;
        logic [5:0] lz;
        p = 6'd0;
        for (int k = 0; k < 50; k++) begin
            if (x.mn[k]) begin
                p = 6'(k);
            end
        end
        lz     = 6'd49 - p;
        y      = x;
        y.zero = (x.mn == 50'd0);
        y.mn   = x.mn << lz;
        y.en   = x.en + $signed({6'b0, p}) - 12'sd47;
        return y;
    endfunction

    // Rounds a normalized value to nearest even, with subnormal and overflow handling.
    function automatic logic [31:0] fround(fl_t x);
        logic [49:0]        mm;
        logic [5:0]         sh;
        logic signed [11:0] sh_full;
        logic               lost;
        logic               g;
        logic               s;
        logic               inc;
        logic [7:0]         expf;
        logic [30:0]        body;
        mm   = x.mn;
        lost = 1'b0;
        expf = x.en[7:0];
        if (x.en <= 12'sd0) begin
            sh_full = 12'sd1 - x.en;
            sh      = (sh_full > 12'sd50) ? 6'd50 : sh_full[5:0];
            mm      = x.mn >> sh;
            lost    = |(x.mn & ~({50{1'b1}} << sh));
            expf    = 8'd0;
        end
        g    = mm[25];
        s    = (|mm[24:0]) | lost;
        body = {expf, mm[48:26]};
        inc  = g & (s | body[0]);
        body = body + {30'd0, inc};
        if (x.spec) begin
            fround = x.sval;
        end else if (x.zero) begin
            fround = {x.sign, 31'd0};
        end else if (x.en >= 12'sd255) begin
            fround = {x.sign, 8'hFF, 23'd0};
        end else begin
            fround = {x.sign, body};
        end
    endfunction

    // Product of a non-negative finite fi and an arbitrary d, before normalization.
    function automatic fl_t fmul(logic [31:0] fi, logic [31:0] d);
        fl_t         y;
        logic        dnan;
        logic        dinf;
        logic        fz;
        logic        dz;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [7:0]  eb;
        logic [47:0] prodm;
        y     = '0;
        dnan  = (d[30:23] == 8'hFF) && (d[22:0] != 23'd0);
        dinf  = (d[30:23] == 8'hFF) && (d[22:0] == 23'd0);
        fz    = (fi[30:0] == 31'd0);
        dz    = (d[30:0] == 31'd0);
        ma    = {1'b1, fi[22:0]};
        mb    = {d[30:23] != 8'd0, d[22:0]};
        eb    = (d[30:23] == 8'd0) ? 8'd1 : d[30:23];
        prodm = ma * mb;
        if (dnan) begin
            y.spec = 1'b1;
            y.sval = d | QUIET_BIT;
        end else if (dinf) begin
            y.spec = 1'b1;
            y.sval = fz ? QNAN_DEFAULT : {d[31], 8'hFF, 23'd0};
        end else if (fz || dz) begin
            y.spec = 1'b1;
            y.sval = {d[31], 31'd0};
        end else begin
            y.sign = d[31];
            y.en   = $signed({4'b0, fi[30:23]}) + $signed({4'b0, eb}) - 12'sd126;
            y.mn   = {2'b0, prodm};
        end
        return y;
    endfunction

    // Sum a + b before normalization; the smaller operand is aligned with sticky.
    function automatic fl_t fadd(logic [31:0] a, logic [31:0] b);
        fl_t         y;
        logic        anan;
        logic        bnan;
        logic        ainf;
        logic        binf;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  ebig;
        logic [7:0]  esml;
        logic [7:0]  diff;
        logic [5:0]  dcl;
        logic [49:0] full;
        logic [49:0] sal;
        logic [49:0] bal;
        y    = '0;
        anan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        bnan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ainf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        binf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (a[30:0] >= b[30:0]) begin
            big = a;
            sml = b;
        end else begin
            big = b;
            sml = a;
        end
        ebig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        esml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        diff = ebig - esml;
        dcl  = (diff > 8'd50) ? 6'd50 : diff[5:0];
        full = {2'b0, sml[30:23] != 8'd0, sml[22:0], 24'd0};
        sal  = (full >> dcl) | {49'd0, |(full & ~({50{1'b1}} << dcl))};
        bal  = {2'b0, big[30:23] != 8'd0, big[22:0], 24'd0};
        if (anan) begin
            y.spec = 1'b1;
            y.sval = a | QUIET_BIT;
        end else if (bnan) begin
            y.spec = 1'b1;
            y.sval = b | QUIET_BIT;
        end else if (ainf && binf && (a[31] != b[31])) begin
            y.spec = 1'b1;
            y.sval = QNAN_DEFAULT;
        end else if (ainf) begin
            y.spec = 1'b1;
            y.sval = a;
        end else if (binf) begin
            y.spec = 1'b1;
            y.sval = b;
        end else begin
            y.en = $signed({4'b0, ebig});
            if (a[31] == b[31]) begin
                y.mn   = bal + sal;
                y.sign = a[31];
            end else begin
                y.mn   = bal - sal;
                // An exact cancellation gives positive zero.
                y.sign = (bal == sal) ? 1'b0 : big[31];
            end
        end
        return y;
    endfunction

endpackage

[design/mrld_ctrl.sv]
// Descriptor parser, run state and symbol registers, ending in the decode register.
module mrld_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // word
    input  logic                s_tlast,   // last
    input  logic                s_tuser,   // action: 0 push, 1 pull
    output logic                p_valid,
    output mrld_pkg::dec_t      p_item,
    input  logic                p_ready
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_FIRST = 2'd2;
    localparam logic [1:0] PH_STEP  = 2'd3;

    logic [31:0] sym_const_reg, sym_ascend_reg, sym_descend_reg, sym_delta_reg, sym_floats_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  kind_reg, kind_next;
    logic [30:0] remaining_reg, remaining_next;
    logic [30:0] index_reg, index_next;
    logic [31:0] first_reg, first_next;
    logic [31:0] step_reg, step_next;
    logic        v_reg;
    mrld_pkg::dec_t item_reg, item_next;
    logic        pending;
    logic        accept;

    assign s_tready = !v_reg || p_ready;
    assign accept   = s_tvalid && s_tready;
    assign pending  = (phase_reg == PH_IDLE) && (remaining_reg != 31'd0);
    assign p_valid  = v_reg;
    assign p_item   = item_reg;

    always_comb begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        remaining_next = remaining_reg;
        index_next     = index_reg;
        first_next     = first_reg;
        step_next      = step_reg;
        item_next      = '0;
        item_next.kind  = kind_reg;
        item_next.index = index_reg;
        item_next.first = first_reg;
        item_next.step  = step_reg;
        item_next.status = mrld_pkg::ST_OK;
        if (s_tuser) begin
            if (pending) begin
                item_next.elem      = 1'b1;
                item_next.val_valid = 1'b1;
                index_next          = index_reg + 31'd1;
                remaining_next      = remaining_reg - 31'd1;
            end else begin
                item_next.status = mrld_pkg::ST_NO_RUN;
            end
        end else if (pending) begin
            item_next.status = mrld_pkg::ST_REFUSED;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    if (s_tdata == sym_const_reg) begin
                        kind_next = mrld_pkg::KIND_CONST;
                    end else if (s_tdata == sym_ascend_reg) begin
                        kind_next = mrld_pkg::KIND_ASCEND;
                    end else if (s_tdata == sym_descend_reg) begin
                        kind_next = mrld_pkg::KIND_DESCEND;
                    end else if (s_tdata == sym_delta_reg) begin
                        kind_next = mrld_pkg::KIND_DELTA;
                    end else if (s_tdata == sym_floats_reg) begin
                        kind_next = mrld_pkg::KIND_FLOAT;
                    end
                    if (s_tdata != sym_const_reg && s_tdata != sym_ascend_reg &&
                        s_tdata != sym_descend_reg && s_tdata != sym_delta_reg &&
                        s_tdata != sym_floats_reg) begin
                        item_next.val_valid = 1'b1;
                        item_next.word      = s_tdata;
                    end else if (s_tlast) begin
                        phase_next       = PH_IDLE;
                        remaining_next   = 31'd0;
                        item_next.status = mrld_pkg::ST_TRUNCATED;
                    end else begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    remaining_next = s_tdata[31] ? 31'd0 : s_tdata[30:0];
                    index_next     = 31'd0;
                    if (s_tlast) begin
                        phase_next       = PH_IDLE;
                        remaining_next   = 31'd0;
                        item_next.status = mrld_pkg::ST_TRUNCATED;
                    end else begin
                        phase_next = PH_FIRST;
                    end
                end
                PH_FIRST: begin
                    first_next = s_tdata;
                    if (kind_reg == mrld_pkg::KIND_DELTA || kind_reg == mrld_pkg::KIND_FLOAT) begin
                        if (s_tlast) begin
                            phase_next       = PH_IDLE;
                            remaining_next   = 31'd0;
                            item_next.status = mrld_pkg::ST_TRUNCATED;
                        end else begin
                            phase_next = PH_STEP;
                        end
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    step_next  = s_tdata;
                    phase_next = PH_IDLE;
                end
            endcase
        end
        item_next.run_pending = (phase_next == PH_IDLE) && (remaining_next != 31'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_const_reg   <= 32'd0;
            sym_ascend_reg  <= 32'd1;
            sym_descend_reg <= 32'd2;
            sym_delta_reg   <= 32'd3;
            sym_floats_reg  <= 32'd4;
            phase_reg       <= PH_IDLE;
            kind_reg        <= mrld_pkg::KIND_CONST;
            remaining_reg   <= 31'd0;
            index_reg       <= 31'd0;
            first_reg       <= 32'd0;
            step_reg        <= 32'd0;
            v_reg           <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    mrld_pkg::REG_SYM_CONST:   sym_const_reg   <= cfg_data;
                    mrld_pkg::REG_SYM_ASCEND:  sym_ascend_reg  <= cfg_data;
                    mrld_pkg::REG_SYM_DESCEND: sym_descend_reg <= cfg_data;
                    mrld_pkg::REG_SYM_DELTA:   sym_delta_reg   <= cfg_data;
                    mrld_pkg::REG_SYM_FLOATS:  sym_floats_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tready) begin
                v_reg <= s_tvalid;
            end
            if (accept) begin
                phase_reg     <= phase_next;
                kind_reg      <= kind_next;
                remaining_reg <= remaining_next;
                index_reg     <= index_next;
                first_reg     <= first_next;
                step_reg      <= step_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

[design/mrld_fpipe.sv]
// Element pipeline: integer run values and the float first + i * step in eight stages.
module mrld_fpipe (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  mrld_pkg::dec_t  in_item,
    output logic            in_ready,
    output logic            out_valid,
    output mrld_pkg::item_t out_item,
    input  logic            out_ready
);

    logic [8:1] v_reg;
    logic [9:1] rdy;
    mrld_pkg::item_t it1_reg, it2_reg, it3_reg, it4_reg, it5_reg, it6_reg, it7_reg, it8_reg;
    mrld_pkg::item_t it1_next, it8_next;
    mrld_pkg::fl_t   n1_reg, r3_reg, n4_reg, r6_reg, n7_reg;
    mrld_pkg::fl_t   i_raw;
    logic [31:0]     fi2_reg, p5_reg;

    // A stage loads when it is empty or its content moves on in the same cycle.
    always_comb begin
        rdy[9] = out_ready;
        for (int k = 8; k >= 1; k--) begin
            rdy[k] = !v_reg[k] || rdy[k + 1];
        end
    end

    assign in_ready  = rdy[1];
    assign out_valid = v_reg[8];
    assign out_item  = it8_reg;

    always_comb begin
        it1_next             = '0;
        it1_next.val_valid   = in_item.val_valid;
        it1_next.run_pending = in_item.run_pending;
        it1_next.status      = in_item.status;
        it1_next.is_float    = in_item.elem && (in_item.kind == mrld_pkg::KIND_FLOAT);
        it1_next.value       = in_item.elem ?
            mrld_pkg::int_elem(in_item.kind, in_item.first, in_item.step, in_item.index) :
            in_item.word;
        it1_next.first       = in_item.first;
        it1_next.step        = in_item.step;
        i_raw    = '0;
        i_raw.en = 12'sd174;
        i_raw.mn = {19'd0, in_item.index};
        it8_next = it7_reg;
        if (it7_reg.is_float) begin
            it8_next.value = mrld_pkg::fround(n7_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 8; k >= 2; k--) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k - 1];
                end
            end
            if (rdy[1]) begin
                v_reg[1] <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            it1_reg <= it1_next;
            n1_reg  <= mrld_pkg::fnorm(i_raw);
        end
        if (rdy[2]) begin
            it2_reg <= it1_reg;
            fi2_reg <= mrld_pkg::fround(n1_reg);
        end
        if (rdy[3]) begin
            it3_reg <= it2_reg;
            r3_reg  <= mrld_pkg::fmul(fi2_reg, it2_reg.step);
        end
        if (rdy[4]) begin
            it4_reg <= it3_reg;
            n4_reg  <= mrld_pkg::fnorm(r3_reg);
        end
        if (rdy[5]) begin
            it5_reg <= it4_reg;
            p5_reg  <= mrld_pkg::fround(n4_reg);
        end
        if (rdy[6]) begin
            it6_reg <= it5_reg;
            r6_reg  <= mrld_pkg::fadd(it5_reg.first, p5_reg);
        end
        if (rdy[7]) begin
            it7_reg <= it6_reg;
            n7_reg  <= mrld_pkg::fnorm(r6_reg);
        end
        if (rdy[8]) begin
            it8_reg <= it8_next;
        end
    end

endmodule

[design/multi_run_length_decoder_unit.sv]
// Top level of the multi run-length decoder: parser followed by the element pipeline.
//
//  Channel   Direction  Handshake            Content
//  s_        in         s_tvalid / s_tready  tdata word, tlast last, tuser action
//  m_        out        m_tvalid / m_tready  tdata valid flag, value, run pending, status
//  cfg_      in         cfg_we               symbol register index and data
//
// One transfer is taken per cycle while m_tready is high; every input transfer gives one
// result transfer after it has passed the decode register and then the element
// pipeline, which holds the float convert, multiply and add as norm/round steps.
// Each pipeline stage holds its item while the next is full, so bubbles close up
// and input is taken as long as any stage can move. Reset is synchronous and
// empties the pipeline at once; no clearing pass follows.
module multi_run_length_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] word
    input  logic        s_tlast,   // last
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] value_valid, [32:1] value, [33] run_pending,
                                   // [35:34] status, [39:36] zero
);

    logic            p_valid;
    logic            p_ready;
    mrld_pkg::dec_t  p_item;
    mrld_pkg::item_t o_item;

    mrld_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .p_valid   (p_valid),
        .p_item    (p_item),
        .p_ready   (p_ready)
    );

    mrld_fpipe u_fpipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_valid),
        .in_item   (p_item),
        .in_ready  (p_ready),
        .out_valid (m_tvalid),
        .out_item  (o_item),
        .out_ready (m_tready)
    );

    assign m_tdata = {4'd0, o_item.status, o_item.run_pending, o_item.value, o_item.val_valid};

endmodule
